@@ design/bollinger_band_tracker_assert.svh @@
// Assertion macros shared by the band tracker RTL.
`ifndef BOLLINGER_BAND_TRACKER_ASSERT_SVH
`define BOLLINGER_BAND_TRACKER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBT_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBT_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

// Condition must never be seen.
`define BBT_ASSERT_NEVER(lbl, ck, rn, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
    else $error(msg);

`endif

@@ design/bbt_pkg.sv @@
// Shared constants and types of the band tracker.
`default_nettype none

package bbt_pkg;

  localparam int WINDOW_MAX  = 64;
  localparam int PRICE_W     = 24;

  localparam int PTR_W       = $clog2(WINDOW_MAX);
  localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
  localparam int WLEN_W      = 7;
  localparam int K_W         = 12;
  localparam int BAND_W      = 29;
  localparam int FRAC_W      = 8;

  localparam int SUM_W       = PRICE_W + PTR_W;
  localparam int SQ_W        = 2 * PRICE_W + PTR_W;
  localparam int ISQ_D_W     = 2 * SUM_W;
  localparam int KR_W        = K_W + SUM_W;
  localparam int NUM_W       = KR_W + 2;
  localparam int DIVQ_W      = NUM_W - FRAC_W;

  localparam int MUL_A_W     = SQ_W;
  localparam int MUL_B_W     = (SUM_W > K_W) ? SUM_W : K_W;
  localparam int MUL_P_W     = (ISQ_D_W > KR_W) ? ISQ_D_W : KR_W;
  localparam int MUL_LEN_W   = $clog2(MUL_B_W + 1);

  localparam int IN_TDATA_W  = ((PRICE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * BAND_W + 7) / 8) * 8;

  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 12;

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(20);
  localparam logic [K_W-1:0]    K_RESET    = K_W'(512);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH  = 1'b0,
    REG_DEVIATION_MULT = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

@@ design/bbt_mul.sv @@
// Bit-serial shift-and-add multiplier, multiplier operand taken MSB first.
`default_nettype none

module bbt_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bbt_pkg::MUL_LEN_W-1:0] len,
  input  logic [bbt_pkg::MUL_A_W-1:0]   a,
  input  logic [bbt_pkg::MUL_B_W-1:0]   b,
  output logic                          done,
  output logic [bbt_pkg::MUL_P_W-1:0]   p
);
  import bbt_pkg::*;

  logic [MUL_A_W-1:0]   a_r, a_nxt;
  logic [MUL_B_W-1:0]   b_r, b_nxt;
  logic [MUL_P_W-1:0]   acc_r, acc_nxt;
  logic [MUL_LEN_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = '0;
      cnt_nxt  = len;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // double the partial product, add the multiplicand for a set bit
      acc_nxt = {acc_r[MUL_P_W-2:0], 1'b0} + (b_r[MUL_B_W-1] ? MUL_P_W'(a_r) : '0);
      b_nxt   = {b_r[MUL_B_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == MUL_LEN_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

`default_nettype wire

@@ design/bbt_isqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
`default_nettype none

module bbt_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bbt_pkg::ISQ_D_W-1:0] d,
  output logic                        done,
  output logic [bbt_pkg::SUM_W-1:0]   root
);
  import bbt_pkg::*;

  localparam int RCNT_W = $clog2(SUM_W + 1);

  logic [ISQ_D_W-1:0] d_r, d_nxt;
  logic [SUM_W+1:0]   rem_r, rem_nxt;
  logic [SUM_W-1:0]   root_r, root_nxt;
  logic [RCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [SUM_W+1:0]   rem_sh;
  logic [SUM_W+1:0]   trial;

  always_comb begin
    rem_sh   = {rem_r[SUM_W-1:0], d_r[ISQ_D_W-1 -: 2]};
    trial    = {root_r, 2'b01};
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      d_nxt    = d;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = RCNT_W'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // bring down two radicand bits, keep the trial if it fits
      d_nxt = {d_r[ISQ_D_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == RCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

@@ design/bbt_div.sv @@
// Restoring bit-serial floor division of a signed value by the window length.
`default_nettype none

module bbt_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bbt_pkg::DIVQ_W-1:0] num,
  input  logic [bbt_pkg::CNT_W-1:0]  den,
  output logic                       done,
  output logic [bbt_pkg::DIVQ_W-1:0] quo
);
  import bbt_pkg::*;

  localparam int DIVU_W = DIVQ_W - 1;
  localparam int DCNT_W = $clog2(DIVQ_W);

  logic [DIVU_W-1:0] u_r, u_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  den_r, den_nxt;
  logic              neg_r, neg_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_dif;
  logic              fits;

  always_comb begin
    rem_sh   = {rem_r, u_r[DIVU_W-1]};
    rem_dif  = rem_sh - {1'b0, den_r};
    fits     = rem_sh >= {1'b0, den_r};
    u_nxt    = u_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // floor of a negative quotient: divide the complement, complement back
      neg_nxt  = num[DIVQ_W-1];
      u_nxt    = num[DIVQ_W-1] ? ~num[DIVU_W-1:0] : num[DIVU_W-1:0];
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = DCNT_W'(DIVU_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      u_nxt   = {u_r[DIVU_W-2:0], fits};
      rem_nxt = fits ? rem_dif[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r   <= u_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign quo  = neg_r ? ~{1'b0, u_r} : {1'b0, u_r};

endmodule

`default_nettype wire

@@ design/bollinger_band_tracker.sv @@
// Top level of the moving-window band tracker: window store, sums and sequencer.
//
// Usage:
//   in_*  : one closing price per transfer; in_tuser set clears the window first.
//   out_* : one upper/lower band pair per transfer, once the window holds N prices.
//   cfg_* : plain write port; index 0 window length (write clears the window),
//           index 1 deviation multiplier in 1/256 steps. Write only while idle.
// Sequencing:
//   An item that completes a full window runs the bit-serial units in turn:
//   squares, S*S with N*Q, square root, k*r and the two division lanes; an
//   item that only fills the window runs the squares alone. The next price is
//   taken only once the sequencer is back in idle.
// Reset: window empty, length 20, multiplier 512, no result pending.
// Stall: the result waits in the output register while the next price is
//   taken; a finished result that meets a full register waits until the
//   receiver takes the older one.
`default_nettype none
`include "bollinger_band_tracker_assert.svh"

module bollinger_band_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bbt_pkg::IN_TDATA_W-1:0]  in_tdata,   // [23:0] price
  input  logic                            in_tuser,   // [0] start_of_series
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bbt_pkg::OUT_TDATA_W-1:0] out_tdata,  // [28:0] upper band, [57:29] lower band
  // configuration
  input  logic                            cfg_wr_en,
  input  logic [bbt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbt_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
  import bbt_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_LOAD = 9'b000000010,
    ST_SQ   = 9'b000000100,
    ST_PGO  = 9'b000001000,
    ST_PROD = 9'b000010000,
    ST_SQRT = 9'b000100000,
    ST_KR   = 9'b001000000,
    ST_DIV  = 9'b010000000,
    ST_EMIT = 9'b100000000
  } state_t;

  // Clamp a floor quotient into the signed band range.
  function automatic logic [BAND_W-1:0] sat_band(input logic [DIVQ_W-1:0] v);
    logic in_range;
    begin
      in_range = (&v[DIVQ_W-1:BAND_W-1]) | ~(|v[DIVQ_W-1:BAND_W-1]);
      if (in_range) begin
        sat_band = v[BAND_W-1:0];
      end else if (v[DIVQ_W-1]) begin
        sat_band = {1'b1, {(BAND_W-1){1'b0}}};
      end else begin
        sat_band = {1'b0, {(BAND_W-1){1'b1}}};
      end
    end
  endfunction

  state_t                 st_r, st_nxt;
  logic [PTR_W-1:0]       wp_r, wp_nxt;
  logic [CNT_W-1:0]       fill_r, fill_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SQ_W-1:0]        sq_r, sq_nxt;
  logic                   drop_r, drop_nxt;
  logic [PRICE_W-1:0]     price_r, price_nxt;
  logic [WLEN_W-1:0]      win_len_r, win_len_nxt;
  logic [K_W-1:0]         k_r, k_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [PRICE_W-1:0]     ring_mem [WINDOW_MAX];
  logic [PRICE_W-1:0]     rd_data_r;

  logic                   in_acc;
  logic [CNT_W-1:0]       n_eff;
  logic [PTR_W-1:0]       wp_acc;
  logic [CNT_W-1:0]       fill_acc;
  logic                   drop_acc;
  logic [PTR_W-1:0]       rd_addr;
  logic [PRICE_W-1:0]     op_eff;

  logic                   m0_start, m1_start, m0_done, m1_done;
  logic [MUL_LEN_W-1:0]   m0_len, m1_len;
  logic [MUL_A_W-1:0]     m0_a, m1_a;
  logic [MUL_B_W-1:0]     m0_b, m1_b;
  logic [MUL_P_W-1:0]     m0_p, m1_p;

  logic                   rt_start, rt_done;
  logic [ISQ_D_W-1:0]     rt_d;
  logic [SUM_W-1:0]       rt_root;

  logic                   dv_start, dvu_done, dvl_done;
  logic [NUM_W-1:0]       num_up, num_lo;
  logic [DIVQ_W-1:0]      dvu_q, dvl_q;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (st_r == ST_IDLE);

  // Effective window length: zero counts as one, anything above the store depth as the depth.
  always_comb begin
    if (win_len_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(win_len_r) > WINDOW_MAX) begin
      n_eff = CNT_W'(WINDOW_MAX);
    end else begin
      n_eff = CNT_W'(win_len_r);
    end
  end

  // Window position as seen by an accepted item, after a start-of-series clear.
  always_comb begin
    wp_acc   = in_tuser ? '0 : wp_r;
    fill_acc = in_tuser ? '0 : fill_r;
    drop_acc = (fill_acc >= n_eff);
    if (32'(wp_acc) >= 32'(n_eff)) begin
      rd_addr = PTR_W'(32'(wp_acc) - 32'(n_eff));
    end else begin
      rd_addr = PTR_W'(32'(wp_acc) + WINDOW_MAX - 32'(n_eff));
    end
  end

  // The price leaving the window; nothing leaves while the window still fills.
  assign op_eff = drop_r ? rd_data_r : '0;

  // Price store: read the leaving price on transfer, write the new one in the cycle after.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= ring_mem[rd_addr];
    end
    if (st_r == ST_LOAD) begin
      ring_mem[wp_r] <= price_r;
    end
  end

  // Operand steering for the two shared multipliers.
  always_comb begin
    case (st_r)
      ST_LOAD: begin
        m0_a   = MUL_A_W'(price_r);
        m0_b   = MUL_B_W'(price_r) << (MUL_B_W - PRICE_W);
        m0_len = MUL_LEN_W'(PRICE_W);
        m1_a   = MUL_A_W'(op_eff);
        m1_b   = MUL_B_W'(op_eff) << (MUL_B_W - PRICE_W);
        m1_len = MUL_LEN_W'(PRICE_W);
      end
      ST_PGO: begin
        m0_a   = MUL_A_W'(sum_r);
        m0_b   = MUL_B_W'(sum_r) << (MUL_B_W - SUM_W);
        m0_len = MUL_LEN_W'(SUM_W);
        m1_a   = MUL_A_W'(sq_r);
        m1_b   = MUL_B_W'(n_eff) << (MUL_B_W - CNT_W);
        m1_len = MUL_LEN_W'(CNT_W);
      end
      default: begin
        m0_a   = MUL_A_W'(rt_root);
        m0_b   = MUL_B_W'(k_r) << (MUL_B_W - K_W);
        m0_len = MUL_LEN_W'(K_W);
        m1_a   = MUL_A_W'(sq_r);
        m1_b   = MUL_B_W'(n_eff) << (MUL_B_W - CNT_W);
        m1_len = MUL_LEN_W'(CNT_W);
      end
    endcase
  end

  assign m0_start = (st_r == ST_LOAD) || (st_r == ST_PGO) || ((st_r == ST_SQRT) && rt_done);
  assign m1_start = (st_r == ST_LOAD) || (st_r == ST_PGO);

  // D = N*Q - S*S, never negative for a consistent window; hold at zero anyway.
  assign rt_d     = (m1_p[ISQ_D_W-1:0] >= m0_p[ISQ_D_W-1:0]) ?
                    (m1_p[ISQ_D_W-1:0] - m0_p[ISQ_D_W-1:0]) : '0;
  assign rt_start = (st_r == ST_PROD) && m0_done;

  // 256*S plus and minus k*r; the low fraction bits drop before the division by N.
  assign num_up   = NUM_W'({sum_r, {FRAC_W{1'b0}}}) + NUM_W'(m0_p[KR_W-1:0]);
  assign num_lo   = NUM_W'({sum_r, {FRAC_W{1'b0}}}) - NUM_W'(m0_p[KR_W-1:0]);
  assign dv_start = (st_r == ST_KR) && m0_done;

  always_comb begin
    st_nxt        = st_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    sq_nxt        = sq_r;
    drop_nxt      = drop_r;
    price_nxt     = price_r;
    win_len_nxt   = win_len_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // drop the held result once the receiver takes it
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          price_nxt = in_tdata[PRICE_W-1:0];
          drop_nxt  = drop_acc;
          if (in_tuser) begin
            wp_nxt   = '0;
            fill_nxt = '0;
            sum_nxt  = '0;
            sq_nxt   = '0;
          end
          st_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        // advance the write pointer, count the price while the window fills
        wp_nxt = (32'(wp_r) == WINDOW_MAX - 1) ? '0 : wp_r + 1'b1;
        if (!drop_r) begin
          fill_nxt = fill_r + 1'b1;
        end
        st_nxt = ST_SQ;
      end
      ST_SQ: begin
        if (m0_done) begin
          sum_nxt = sum_r - SUM_W'(op_eff) + SUM_W'(price_r);
          sq_nxt  = sq_r - m1_p[SQ_W-1:0] + m0_p[SQ_W-1:0];
          st_nxt  = (fill_r >= n_eff) ? ST_PGO : ST_IDLE;
        end
      end
      ST_PGO: begin
        st_nxt = ST_PROD;
      end
      ST_PROD: begin
        if (m0_done) begin
          st_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (rt_done) begin
          st_nxt = ST_KR;
        end
      end
      ST_KR: begin
        if (m0_done) begin
          st_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (dvu_done) begin
          st_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold the finished bands until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'({sat_band(dvl_q), sat_band(dvu_q)});
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    // register writes come last so a window-length write always clears the window
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_WINDOW_LENGTH: begin
          win_len_nxt = cfg_wr_data[WLEN_W-1:0];
          wp_nxt      = '0;
          fill_nxt    = '0;
          sum_nxt     = '0;
          sq_nxt      = '0;
        end
        REG_DEVIATION_MULT: begin
          k_nxt = cfg_wr_data[K_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      win_len_r   <= WLEN_RESET;
      k_r         <= K_RESET;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      win_len_r   <= win_len_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    drop_r     <= drop_nxt;
    price_r    <= price_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // m0: new square, then S*S, then k*r; m1: leaving square, then N*Q
  bbt_mul u_mul0 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (m0_start),
    .len   (m0_len),
    .a     (m0_a),
    .b     (m0_b),
    .done  (m0_done),
    .p     (m0_p)
  );

  bbt_mul u_mul1 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (m1_start),
    .len   (m1_len),
    .a     (m1_a),
    .b     (m1_b),
    .done  (m1_done),
    .p     (m1_p)
  );

  bbt_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rt_start),
    .d     (rt_d),
    .done  (rt_done),
    .root  (rt_root)
  );

  bbt_div u_div_up (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (num_up[NUM_W-1:FRAC_W]),
    .den   (n_eff),
    .done  (dvu_done),
    .quo   (dvu_q)
  );

  bbt_div u_div_lo (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (num_lo[NUM_W-1:FRAC_W]),
    .den   (n_eff),
    .done  (dvl_done),
    .quo   (dvl_q)
  );

  `BBT_ASSERT_NEVER(a_fill_bound, clk, rst_n, fill_r > n_eff, "fill count above window length")
  `BBT_ASSERT_NEXT(a_accept_load, clk, rst_n, in_acc, st_r == ST_LOAD, "transfer not followed by load")
  `BBT_ASSERT_IMPLY(a_sq_pair, clk, rst_n, (st_r == ST_SQ) && m0_done, m1_done, "square products out of step")
  `BBT_ASSERT_IMPLY(a_div_pair, clk, rst_n, dvu_done, (st_r == ST_DIV) && dvl_done, "division lanes out of step")

endmodule

`default_nettype wire
